// File: src/lfpj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpj_pkg
// Shared types and constants for the line follower PID and junction logger.
// ----------------------------------------------------------------------------
package lfpj_pkg;

  localparam int unsigned NUM_SENSORS = 8;
  localparam int unsigned DIV_W       = 12;  // |weight sum| * 256 fits here
  localparam int unsigned CNT_W       = 4;   // active sensor count 0..8

  // sensor weights, 2.5 truncated to 2
  localparam logic signed [3:0] SENSOR_WEIGHT [NUM_SENSORS] = '{
    -4'sd7, -4'sd5, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd5, 4'sd7
  };

  // configuration register indexes
  localparam logic [1:0] REG_DRIVE_BASE = 2'd0;
  localparam logic [1:0] REG_GAIN_P     = 2'd1;
  localparam logic [1:0] REG_GAIN_I     = 2'd2;
  localparam logic [1:0] REG_GAIN_D     = 2'd3;

  localparam logic [7:0]  DRIVE_BASE_RST = 8'd60;
  localparam logic [23:0] GAIN_P_RST     = 24'd655360;
  localparam logic [23:0] GAIN_I_RST     = 24'd7;
  localparam logic [23:0] GAIN_D_RST     = 24'd6553600;

  localparam logic [1:0] SYM_S = 2'd0;
  localparam logic [1:0] SYM_L = 2'd1;
  localparam logic [1:0] SYM_U = 2'd2;

  typedef enum logic [3:0] {
    MAN_FOLLOW = 4'd0,
    MAN_FINISH = 4'd1,
    MAN_FOUR   = 4'd2,
    MAN_TEE    = 4'd3,
    MAN_LJ     = 4'd4,
    MAN_RJ     = 4'd5,
    MAN_LEFT   = 4'd6,
    MAN_RIGHT  = 4'd7,
    MAN_UTURN  = 4'd8
  } maneuver_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MERGE,
    S_DIV,
    S_INTEG,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC,
    S_POST
  } state_t;

  typedef struct packed {
    logic [7:0] line_pattern;
    logic [7:0] settled_pattern;
    logic       clear_path;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]         maneuver;
    logic [7:0]         left_speed;
    logic [7:0]         right_speed;
    logic signed [11:0] position_error;
    logic               path_written;
    logic [1:0]         path_symbol;
    logic [5:0]         path_count;
  } out_beat_t;

  // classifier verdict
  typedef struct packed {
    maneuver_t  man;
    logic       centred;
    logic       log_ok;   // symbol to append and settled pattern centred
    logic [1:0] sym;
  } class_t;

endpackage
`default_nettype wire

// File: src/lfpj_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpj_lane
// One sensor lane: registers the sensor's weight contribution and activity.
// ----------------------------------------------------------------------------
module lfpj_lane (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic              sensor,
  input  wire logic signed [3:0] weight,
  output logic signed [3:0]      contrib,
  output logic                   active
);
  // contribution is the weight when the sensor sees the line
  always_ff @(posedge clk) begin
    if (load) begin
      contrib <= sensor ? weight : 4'sd0;
      active  <= sensor;
    end
  end
endmodule
`default_nettype wire

// File: src/lfpj_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpj_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfpj_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [lfpj_pkg::DIV_W-1:0] dividend,
  input  wire logic [lfpj_pkg::CNT_W-1:0] divisor,
  output logic done,
  output logic [lfpj_pkg::DIV_W-1:0] quotient
);
  import lfpj_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DIV_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic              qbit;

  // trial subtraction of the next dividend bit
  always_comb begin
    trial = {rem, dvd[DIV_W-1]};
    qbit  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DIV_W-2:0], 1'b0};
      rem      <= qbit ? CNT_W'(trial - {1'b0, dsr}) : trial[CNT_W-1:0];
      quotient <= {quotient[DIV_W-2:0], qbit};
    end
  end
endmodule
`default_nettype wire

// File: src/lfpj_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpj_classify
// Sorts a line pattern into follow, finish, junction, turn or U-turn.
// ----------------------------------------------------------------------------
module lfpj_classify (
  input  wire logic [7:0] pattern,
  input  wire logic [7:0] settled,
  input  wire logic       was_on_line,
  output lfpj_pkg::class_t verdict
);
  import lfpj_pkg::*;

  logic       has_sym;
  logic       settled_centred;

  always_comb begin
    settled_centred = (settled == 8'h18) || (settled == 8'h10) || (settled == 8'h08);
  end

  always_comb begin
    verdict.man     = MAN_FOLLOW;
    verdict.centred = 1'b0;
    verdict.sym     = SYM_S;
    has_sym         = 1'b0;
    case (pattern)
      8'h18, 8'h10, 8'h08: begin
        verdict.centred = 1'b1;
      end
      8'hFF, 8'h7E, 8'h7F, 8'hFE: begin
        verdict.man = MAN_FINISH;
      end
      8'h99, 8'hDB, 8'h91, 8'h89, 8'h5A, 8'h5B, 8'hDA, 8'h92, 8'h52, 8'h59: begin
        verdict.man = MAN_FOUR;
        has_sym     = 1'b1;
      end
      8'h81, 8'h42, 8'hC3, 8'h43, 8'hC2: begin
        verdict.man = MAN_TEE;
        verdict.sym = SYM_L;
        has_sym     = 1'b1;
      end
      8'h98, 8'h90, 8'h88, 8'h84, 8'h8C, 8'hB0, 8'h50, 8'h58, 8'h48, 8'h5C,
      8'h4C: begin
        verdict.man = MAN_LJ;
        verdict.sym = SYM_L;
        has_sym     = 1'b1;
      end
      8'h19, 8'h11, 8'h09, 8'h21, 8'h31, 8'h0D, 8'h0A, 8'h1A, 8'h12, 8'h3A,
      8'h32: begin
        verdict.man = MAN_RJ;
        has_sym     = 1'b1;
      end
      default: begin
        // plain turns, then U-turn once the line has been seen
        if ((pattern[7:6] != 2'b00) && (pattern[4:3] == 2'b00)) begin
          verdict.man = MAN_LEFT;
        end else if ((pattern[1:0] != 2'b00) && (pattern[4:3] == 2'b00)) begin
          verdict.man = MAN_RIGHT;
        end else if ((pattern == 8'h00) && was_on_line) begin
          verdict.man = MAN_UTURN;
          verdict.sym = SYM_U;
          has_sym     = 1'b1;
        end
      end
    endcase
    verdict.log_ok = has_sym && settled_centred;
  end
endmodule
`default_nettype wire

// File: src/line_follow_pid_junction_logger_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The restoring divide runs for every beat and takes most of the time from
// input beat to result beat.
// A new item is taken only once the previous one has reached the output
// register; the next item is taken while the result beat waits there.
// Reset: synchronous; restores register defaults, clears PID state and the
// path count. The path store itself is not cleared.
// ----------------------------------------------------------------------------
// line_follow_pid_junction_logger_unit
// Line follower step: eight sensor lanes, merge, divide, shared PID
// multiplier, drive clamp, junction classifier and path log.
// ----------------------------------------------------------------------------
module line_follow_pid_junction_logger_unit #(
  parameter int unsigned PATH_DEPTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lfpj_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lfpj_pkg::out_beat_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [23:0]         cfg_data
);
  import lfpj_pkg::*;

  localparam int unsigned LEN_W  = $clog2(PATH_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(PATH_DEPTH);

  // configuration
  logic [7:0]  drive_base;
  logic [23:0] gain_p, gain_i, gain_d;

  // PID and path state
  logic signed [11:0] last_error;
  logic signed [23:0] error_integral;
  logic               was_on_line;
  logic [LEN_W-1:0]   path_length;
  logic [1:0]         path_store [PATH_DEPTH];

  // per-item registers
  state_t             state, state_next;
  logic [7:0]         pat_r, settled_r;
  logic               clear_r;
  logic signed [6:0]  sum_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [11:0] err_r;
  logic signed [12:0] deriv_r;
  logic signed [48:0] prod;
  logic signed [49:0] acc;

  // control
  logic accept, div_start, out_free, post_load;
  logic div_done;
  logic [DIV_W-1:0] quot;

  // lanes
  logic signed [3:0] lane_contrib [NUM_SENSORS];
  logic              lane_active  [NUM_SENSORS];

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    lfpj_lane u_lane (
      .clk     (clk),
      .load    (accept),
      .sensor  (in_data.line_pattern[g]),
      .weight  (SENSOR_WEIGHT[g]),
      .contrib (lane_contrib[g]),
      .active  (lane_active[g])
    );
  end

  // merge of lane results
  logic signed [6:0] sum_c;
  logic [CNT_W-1:0]  cnt_c;
  logic [3:0]        mag_c;
  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sum_c = sum_c + 7'(lane_contrib[i]);
      cnt_c = cnt_c + CNT_W'(lane_active[i]);
    end
    mag_c = sum_c[6] ? 4'(-sum_c) : sum_c[3:0];
  end

  lfpj_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag_c, 8'h00}),
    .divisor  (cnt_c),
    .done     (div_done),
    .quotient (quot)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MERGE;
      S_MERGE: state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_INTEG;
      S_INTEG: state_next = S_MUL_P;
      S_MUL_P: state_next = S_MUL_I;
      S_MUL_I: state_next = S_MUL_D;
      S_MUL_D: state_next = S_ACC;
      S_ACC:   state_next = S_POST;
      S_POST:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state != S_IDLE);
    div_start = (state == S_MERGE);
    post_load = (state == S_POST) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_base <= DRIVE_BASE_RST;
      gain_p     <= GAIN_P_RST;
      gain_i     <= GAIN_I_RST;
      gain_d     <= GAIN_D_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRIVE_BASE: drive_base <= cfg_data[7:0];
        REG_GAIN_P:     gain_p     <= cfg_data;
        REG_GAIN_I:     gain_i     <= cfg_data;
        REG_GAIN_D:     gain_d     <= cfg_data;
        default: ;
      endcase
    end
  end

  // error from divide, integral update
  logic signed [11:0] err_c;
  logic signed [24:0] integ_sum;
  logic signed [23:0] integ_base;
  always_comb begin
    err_c = (cnt_r == '0) ? last_error
          : (sum_r[6] ? -$signed(quot) : $signed(quot));
    integ_base = error_integral;
    if ((cnt_r != '0) && (((err_c < 0) && (last_error > 0)) ||
                          ((err_c > 0) && (last_error < 0)))) begin
      integ_base = '0;
    end
    integ_sum = 25'(integ_base) + 25'(err_c);
  end

  // shared multiplier operand select
  logic signed [24:0] mul_a;
  logic signed [23:0] mul_b;
  always_comb begin
    case (state)
      S_MUL_I: begin
        mul_a = $signed({1'b0, gain_i});
        mul_b = error_integral;
      end
      S_MUL_D: begin
        mul_a = $signed({1'b0, gain_d});
        mul_b = 24'(deriv_r);
      end
      default: begin
        mul_a = $signed({1'b0, gain_p});
        mul_b = 24'(err_r);
      end
    endcase
  end

  // drive clamp
  logic signed [50:0] base_ext, v_left, v_right;
  logic [7:0]         left_c, right_c;
  always_comb begin
    base_ext = $signed({19'd0, drive_base, 24'd0});
    v_left   = base_ext - 51'(acc);
    v_right  = base_ext + 51'(acc);
    if (v_left[50])                    left_c = 8'd0;
    else if (v_left[49:32] != '0)      left_c = 8'd255;
    else                               left_c = v_left[31:24];
    if (v_right[50])                   right_c = 8'd0;
    else if (v_right[49:32] != '0)     right_c = 8'd255;
    else                               right_c = v_right[31:24];
  end

  class_t verdict;
  lfpj_classify u_class (
    .pattern     (pat_r),
    .settled     (settled_r),
    .was_on_line (was_on_line),
    .verdict     (verdict)
  );

  // path append
  logic [LEN_W-1:0] len_base;
  logic             do_write;
  always_comb begin
    len_base = clear_r ? '0 : path_length;
    do_write = verdict.log_ok && (len_base < LEN_W'(PATH_DEPTH));
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (accept) begin
      pat_r     <= in_data.line_pattern;
      settled_r <= in_data.settled_pattern;
      clear_r   <= in_data.clear_path;
    end
    if (state == S_MERGE) begin
      sum_r <= sum_c;
      cnt_r <= cnt_c;
    end
    if (state == S_INTEG) begin
      err_r   <= err_c;
      deriv_r <= 13'(err_c) - 13'(last_error);
    end
    if ((state == S_MUL_P) || (state == S_MUL_I) || (state == S_MUL_D)) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_MUL_I) acc <= 50'(prod);
    if ((state == S_MUL_D) || (state == S_ACC)) acc <= acc + 50'(prod);
  end

  // PID state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error     <= '0;
      error_integral <= '0;
      was_on_line    <= 1'b0;
      path_length    <= '0;
    end else begin
      if (state == S_INTEG) begin
        if (integ_sum > 25'sd8388607)       error_integral <= 24'sh7FFFFF;
        else if (integ_sum < -25'sd8388608) error_integral <= 24'sh800000;
        else                                error_integral <= integ_sum[23:0];
      end
      if (post_load) begin
        last_error <= err_r;
        if (verdict.man >= MAN_FOUR) error_integral <= '0;
        if (verdict.centred) was_on_line <= 1'b1;
        path_length <= do_write ? len_base + 1'b1 : len_base;
      end
    end
  end

  // path store
  always_ff @(posedge clk) begin
    if (post_load && do_write) path_store[len_base[ADDR_W-1:0]] <= verdict.sym;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_load) begin
      out_data.maneuver       <= verdict.man;
      out_data.left_speed     <= left_c;
      out_data.right_speed    <= right_c;
      out_data.position_error <= err_r;
      out_data.path_written   <= do_write;
      out_data.path_symbol    <= do_write ? verdict.sym : SYM_S;
      out_data.path_count     <= 6'(do_write ? len_base + 1'b1 : len_base);
    end
  end
endmodule
`default_nettype wire

// File: tb/tb_line_follow_pid_junction_logger_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PID / junction logger testbench
// Drives pattern beats through the valid/stall handshake under random idling,
// predicts every result beat from a behavioural model of the step held in a
// scoreboard class, and compares result beats field by field in order.
// ----------------------------------------------------------------------------
module tb_line_follow_pid_junction_logger_unit;
  import lfpj_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DEPTH = 32;

  // scoreboard: steering model plus queue of expected result beats
  class steer_scoreboard;
    logic [7:0]  base;
    logic [23:0] kp, ki, kd;
    int          prev_err;
    int          integ;
    bit          seen_line;
    int          path_len;
    out_beat_t   pending[$];
    int          errors;

    function void reset_state();
      base = DRIVE_BASE_RST; kp = GAIN_P_RST; ki = GAIN_I_RST; kd = GAIN_D_RST;
      prev_err = 0; integ = 0; seen_line = 0; path_len = 0;
      pending.delete(); errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        REG_DRIVE_BASE: base = val[7:0];
        REG_GAIN_P:     kp = val;
        REG_GAIN_I:     ki = val;
        REG_GAIN_D:     kd = val;
        default: ;
      endcase
    endfunction

    function bit is_centred(logic [7:0] p);
      return p == 8'h18 || p == 8'h10 || p == 8'h08;
    endfunction

    function logic [7:0] clamp_drive(longint v);
      if (v < 0) return 8'd0;
      v = v >>> 24;
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function void note_input(in_beat_t b);
      int sum, cnt, err, deriv;
      longint acc, corr, bs;
      maneuver_t man;
      bit has_sym;
      logic [1:0] sym;
      logic [7:0] p;
      out_beat_t r;
      p = b.line_pattern; sum = 0; cnt = 0; has_sym = 0; sym = SYM_S;
      if (b.clear_path) path_len = 0;
      for (int i = 0; i < 8; i++)
        if (p[i]) begin
          sum += SENSOR_WEIGHT[i]; cnt++;
        end
      if (cnt > 0) begin
        err = (sum * 256) / cnt;
        if ((err < 0 && prev_err > 0) || (err > 0 && prev_err < 0)) integ = 0;
      end else err = prev_err;
      acc = longint'(integ) + err;
      if (acc > 8388607) acc = 8388607;
      if (acc < -8388608) acc = -8388608;
      integ = int'(acc);
      deriv = err - prev_err;
      corr = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * deriv;
      bs = longint'(base) * 64'sd16777216;
      r.left_speed = clamp_drive(bs - corr);
      r.right_speed = clamp_drive(bs + corr);
      prev_err = err;
      // classify the raw pattern
      if (is_centred(p)) begin
        man = MAN_FOLLOW; seen_line = 1;
      end else if (p inside {8'hFF, 8'h7E, 8'h7F, 8'hFE}) man = MAN_FINISH;
      else if (p inside {8'h99, 8'hDB, 8'h91, 8'h89, 8'h5A, 8'h5B, 8'hDA, 8'h92,
                         8'h52, 8'h59}) begin
        man = MAN_FOUR; has_sym = 1; sym = SYM_S;
      end else if (p inside {8'h81, 8'h42, 8'hC3, 8'h43, 8'hC2}) begin
        man = MAN_TEE; has_sym = 1; sym = SYM_L;
      end else if (p inside {8'h98, 8'h90, 8'h88, 8'h84, 8'h8C, 8'hB0, 8'h50, 8'h58,
                             8'h48, 8'h5C, 8'h4C}) begin
        man = MAN_LJ; has_sym = 1; sym = SYM_L;
      end else if (p inside {8'h19, 8'h11, 8'h09, 8'h21, 8'h31, 8'h0D, 8'h0A, 8'h1A,
                             8'h12, 8'h3A, 8'h32}) begin
        man = MAN_RJ; has_sym = 1; sym = SYM_S;
      end else if ((p & 8'hC0) != 0 && (p & 8'h18) == 0) man = MAN_LEFT;
      else if ((p & 8'h03) != 0 && (p & 8'h18) == 0) man = MAN_RIGHT;
      else if (p == 0 && seen_line) begin
        man = MAN_UTURN; has_sym = 1; sym = SYM_U;
      end else man = MAN_FOLLOW;
      if (man >= MAN_FOUR) integ = 0;
      r.path_written = 0; r.path_symbol = SYM_S;
      if (has_sym && path_len < DEPTH && is_centred(b.settled_pattern)) begin
        path_len++; r.path_written = 1; r.path_symbol = sym;
      end
      r.maneuver = man;
      r.position_error = err[11:0];
      r.path_count = path_len[5:0];
      pending.push_back(r);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.maneuver !== e.maneuver) begin
        $error("maneuver exp %0d got %0d", e.maneuver, got.maneuver); errors++;
      end
      if (got.left_speed !== e.left_speed) begin
        $error("left_speed exp %0d got %0d", e.left_speed, got.left_speed); errors++;
      end
      if (got.right_speed !== e.right_speed) begin
        $error("right_speed exp %0d got %0d", e.right_speed, got.right_speed);
        errors++;
      end
      if (got.position_error !== e.position_error) begin
        $error("position_error exp %0d got %0d", e.position_error, got.position_error);
        errors++;
      end
      if (got.path_written !== e.path_written) begin
        $error("path_written exp %0d got %0d", e.path_written, got.path_written);
        errors++;
      end
      if (got.path_symbol !== e.path_symbol) begin
        $error("path_symbol exp %0d got %0d", e.path_symbol, got.path_symbol);
        errors++;
      end
      if (got.path_count !== e.path_count) begin
        $error("path_count exp %0d got %0d", e.path_count, got.path_count); errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_beat_t out_data;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = REG_DRIVE_BASE;
  logic [23:0] cfg_data = '0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off = 0;
  int  quiet_cycles = 0;
  steer_scoreboard sb;

  always #6 clk = ~clk;

  line_follow_pid_junction_logger_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // receiver: random stall, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // result check and watchdog at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // send one beat after the previous release, idling at random
  task automatic send_beat(logic [7:0] p, logic [7:0] s, logic c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1;
    in_data <= '{line_pattern: p, settled_pattern: s, clear_path: c};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(in_data);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [7:0] pick_pattern();
    logic [7:0] table_pick [16] = '{8'h18, 8'h10, 8'h08, 8'hFF, 8'h99, 8'h81,
      8'h98, 8'h19, 8'hC0, 8'h03, 8'h00, 8'h5A, 8'h42, 8'h50, 8'h3A, 8'h7E};
    if ($urandom_range(1)) return table_pick[4'($urandom_range(15))];
    return 8'($urandom_range(255));
  endfunction

  task automatic random_run(int n);
    logic [7:0] p, s;
    for (int i = 0; i < n; i++) begin
      p = pick_pattern();
      case ($urandom_range(3))
        0: s = p;
        1: s = 8'($urandom_range(255));
        default: s = ($urandom_range(1)) ? 8'h18 : 8'h08;
      endcase
      send_beat(p, s, $urandom_range(39) == 0);
    end
  endtask

  initial begin
    logic [7:0] directed [] = '{8'h00, 8'h18, 8'h01, 8'h80, 8'hFF, 8'h99, 8'h81,
      8'h98, 8'h19, 8'hC0, 8'h03, 8'h00, 8'h10, 8'h08, 8'h24, 8'h7F, 8'h55, 8'hAA};
    sb = new();
    sb.reset_state();
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: empty before seen, extremes, every maneuver kind
    foreach (directed[i]) send_beat(directed[i], 8'h18, 0);
    send_beat(8'hFF, 8'hFF, 1);
    // fill the path store past its depth
    for (int i = 0; i < 36; i++) send_beat(8'h99, 8'h10, 0);
    drain();

    // phase 1: sender idles lightly, receiver heavily
    send_idle_pct = 19; recv_idle_pct = 65;
    write_reg(REG_DRIVE_BASE, 24'd255);
    write_reg(REG_GAIN_P, 24'hFFFFFF);
    write_reg(REG_GAIN_I, 24'hFFFFFF);
    write_reg(REG_GAIN_D, 24'h000000);
    send_beat(8'h80, 8'h00, 1);
    random_run(130);
    drain();

    // phase 2: the other way round, P and I gains zero, D gain at its maximum
    send_idle_pct = 65; recv_idle_pct = 19;
    write_reg(REG_DRIVE_BASE, 24'd0);
    write_reg(REG_GAIN_P, 24'd0);
    write_reg(REG_GAIN_I, 24'd0);
    write_reg(REG_GAIN_D, 24'hFFFFFF);
    random_run(130);
    drain();

    // phase 3: no idling, long receiver hold-off fills the block
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_DRIVE_BASE, 24'd128);
    write_reg(REG_GAIN_P, 24'd65536);
    write_reg(REG_GAIN_I, 24'd300);
    write_reg(REG_GAIN_D, 24'd200000);
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      random_run(20);
    join
    random_run(200);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
